### hw/rtl/tsn_pkg.sv
// ----------------------------------------------------------------------------
// tsn_pkg: shared types and constants of the text display filter
// Descriptor that travels from the classifier to the byte sequencer, the
// sequencer phases, register indexes and the display characters.
// ----------------------------------------------------------------------------
package tsn_pkg;

   localparam int CSR_INDEX_W = 3;

   localparam logic [CSR_INDEX_W-1:0] CSR_SQUEEZE_BLANK    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_ALL       = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_NUMBER_NONBLANK  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_ENDS        = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_TABS        = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHOW_NONPRINTING = 3'd5;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_DASH   = 8'h2d;
   localparam logic [7:0] CH_QMARK  = 8'h3f;
   localparam logic [7:0] CH_UPPER_I = 8'h49;
   localparam logic [7:0] CH_UPPER_M = 8'h4d;
   localparam logic [7:0] CH_CARET  = 8'h5e;
   localparam logic [7:0] CH_DEL    = 8'h7f;
   localparam logic [7:0] CH_HIGH_CTRL_LAST = 8'h9f;
   localparam logic [7:0] CH_CTRL_LAST      = 8'h1f;
   localparam logic [7:0] CH_LOW_CTRL_LAST  = 8'h08;
   localparam logic [7:0] CH_HIGH_FIRST     = 8'h80;
   localparam logic [7:0] CH_HIGH_PRINT     = 8'ha0;
   localparam logic [7:0] CH_ALL_ONES       = 8'hff;
   localparam logic [7:0] CTRL_OFFSET       = 8'd64;
   localparam logic [7:0] HIGH_OFFSET       = 8'd128;

   typedef enum logic [1:0] {
      PFX_NONE        = 2'd0,
      PFX_CARET       = 2'd1,
      PFX_MDASH       = 2'd2,
      PFX_MDASH_CARET = 2'd3
   } prefix_type;

   typedef struct packed {
      logic       num;
      logic       dollar;
      prefix_type prefix;
      logic [7:0] ch;
   } desc_type;

   typedef enum logic [6:0] {
      PH_DIGIT  = 7'b0000001,
      PH_TAB    = 7'b0000010,
      PH_DOLLAR = 7'b0000100,
      PH_M      = 7'b0001000,
      PH_DASH   = 7'b0010000,
      PH_CARET  = 7'b0100000,
      PH_CHAR   = 7'b1000000
   } phase_type;

endpackage

### hw/rtl/tsn_front.sv
// ----------------------------------------------------------------------------
// tsn_front: input classifier
// Holds the option registers and line state, takes one input beat a cycle
// if the queue has room, turns each shown byte into a sequencer descriptor.
// ----------------------------------------------------------------------------
module tsn_front #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [tsn_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic                                 csr_data,
   input  logic                                 req_push,
   output logic                                 req_full,
   input  logic                                 req_cmd,
   input  logic [7:0]                           req_in_byte,
   input  logic                                 q_full,
   output logic                                 q_push,
   output tsn_pkg::desc_type                    q_desc,
   output logic [4*NUMBER_DIGITS-1:0]           q_num
);
   import tsn_pkg::*;

   localparam int NW = 4 * NUMBER_DIGITS;

   logic squeeze_ff, num_all_ff, num_nb_ff, ends_ff, tabs_ff, nonprint_ff;
   logic line_start_ff, line_start_in;
   logic blank_ff, blank_in;
   logic exempt_ff, exempt_in;
   logic [NW-1:0] line_ff, line_in, line_inc;

   logic       accept, nl, sq_active, drop, do_num;
   prefix_type pfx;
   logic [7:0] ch;
   logic       carry, all_nines;
   logic [3:0] dgt;

   assign csr_ready = 1'b1;
   assign req_full  = q_full;
   assign accept    = req_push && !q_full;

   always_ff @(posedge clock) begin
      if (reset) begin
         squeeze_ff  <= 1'b0;
         num_all_ff  <= 1'b0;
         num_nb_ff   <= 1'b0;
         ends_ff     <= 1'b0;
         tabs_ff     <= 1'b0;
         nonprint_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SQUEEZE_BLANK:    squeeze_ff  <= csr_data;
            CSR_NUMBER_ALL:       num_all_ff  <= csr_data;
            CSR_NUMBER_NONBLANK:  num_nb_ff   <= csr_data;
            CSR_SHOW_ENDS:        ends_ff     <= csr_data;
            CSR_SHOW_TABS:        tabs_ff     <= csr_data;
            CSR_SHOW_NONPRINTING: nonprint_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign nl        = (req_in_byte == CH_NL);
   assign sq_active = squeeze_ff && !exempt_ff;
   assign drop      = sq_active && line_start_ff && nl && blank_ff;
   assign do_num    = num_nb_ff ? (line_start_ff && !nl) : (num_all_ff && line_start_ff);

   // Saturating decimal increment, least significant digit first.
   always_comb begin
      carry     = 1'b1;
      all_nines = 1'b1;
      line_inc  = line_ff;
      for (int i = 0; i < NUMBER_DIGITS; i++) begin
         dgt = line_ff[4*i +: 4];
         all_nines = all_nines && (dgt == 4'd9);
         if (carry) begin
            if (dgt == 4'd9) begin
               line_inc[4*i +: 4] = 4'd0;
            end else begin
               line_inc[4*i +: 4] = dgt + 4'd1;
               carry = 1'b0;
            end
         end
      end
      if (all_nines) begin
         line_inc = line_ff;
      end
   end

   always_comb begin
      pfx = PFX_NONE;
      ch  = req_in_byte;
      if (tabs_ff && req_in_byte == CH_TAB) begin
         pfx = PFX_CARET;
         ch  = CH_UPPER_I;
      end else if (nonprint_ff) begin
         if (req_in_byte <= CH_LOW_CTRL_LAST ||
             (req_in_byte > CH_NL && req_in_byte <= CH_CTRL_LAST)) begin
            pfx = PFX_CARET;
            ch  = req_in_byte + CTRL_OFFSET;
         end else if (req_in_byte == CH_DEL) begin
            pfx = PFX_CARET;
            ch  = CH_QMARK;
         end else if (req_in_byte >= CH_HIGH_FIRST && req_in_byte <= CH_HIGH_CTRL_LAST) begin
            pfx = PFX_MDASH_CARET;
            ch  = req_in_byte - CTRL_OFFSET;
         end else if (req_in_byte == CH_ALL_ONES) begin
            pfx = PFX_MDASH_CARET;
            ch  = CH_QMARK;
         end else if (req_in_byte >= CH_HIGH_PRINT) begin
            pfx = PFX_MDASH;
            ch  = req_in_byte - HIGH_OFFSET;
         end
      end
   end

   assign q_push        = accept && !req_cmd && !drop;
   assign q_desc.num    = do_num;
   assign q_desc.dollar = ends_ff && nl;
   assign q_desc.prefix = pfx;
   assign q_desc.ch     = ch;
   assign q_num         = line_ff;

   always_comb begin
      line_start_in = line_start_ff;
      blank_in      = blank_ff;
      exempt_in     = exempt_ff;
      line_in       = line_ff;
      if (accept && req_cmd) begin
         // end of file: restart line and count, exempt the next byte
         line_start_in = 1'b1;
         exempt_in     = 1'b1;
         line_in       = {{(NW-4){1'b0}}, 4'd1};
      end else if (q_push) begin
         if (sq_active) begin
            blank_in = line_start_ff && nl;
         end
         line_start_in = nl;
         exempt_in     = 1'b0;
         if (do_num) begin
            line_in = line_inc;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_start_ff <= 1'b1;
         blank_ff      <= 1'b0;
         exempt_ff     <= 1'b0;
         line_ff       <= {{(NW-4){1'b0}}, 4'd1};
      end else begin
         line_start_ff <= line_start_in;
         blank_ff      <= blank_in;
         exempt_ff     <= exempt_in;
         line_ff       <= line_in;
      end
   end

endmodule

### hw/rtl/tsn_fifo.sv
// ----------------------------------------------------------------------------
// tsn_fifo: descriptor queue
// Small register queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module tsn_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import tsn_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
   localparam logic [CW-1:0] DEPTH_CNT = CW'(DEPTH);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == DEPTH_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PW'(1);
         end
      end
   end

endmodule

### hw/rtl/tsn_back.sv
// ----------------------------------------------------------------------------
// tsn_back: display byte sequencer
// Walks one descriptor through its phases (number digits, tab, dollar,
// M, dash, caret, character), one display byte a cycle into the output
// register while that register is free or being popped.
// ----------------------------------------------------------------------------
module tsn_back #(
   parameter int NUMBER_DIGITS = 6
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_empty,
   input  tsn_pkg::desc_type           q_desc,
   input  logic [4*NUMBER_DIGITS-1:0]  q_num,
   output logic                        q_pop,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output logic [7:0]                  rsp_out_byte,
   output logic                        rsp_last
);
   import tsn_pkg::*;

   localparam int IW = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(NUMBER_DIGITS - 1);

   logic          first_ff;
   phase_type     phase_ff, cur_phase, next_phase, first_phase;
   phase_type     after_tab, after_dollar;
   logic [IW-1:0] idx_ff, cur_idx, next_idx;
   logic          valid_ff;
   logic [7:0]    byte_ff, step_byte, digit_char;
   logic          last_ff, advance;
   logic          seen, is_blank;
   logic [3:0]    dgt, sel_dgt;

   assign after_dollar = (q_desc.prefix == PFX_MDASH || q_desc.prefix == PFX_MDASH_CARET)
                         ? PH_M : ((q_desc.prefix == PFX_CARET) ? PH_CARET : PH_CHAR);
   assign after_tab    = q_desc.dollar ? PH_DOLLAR : after_dollar;
   assign first_phase  = q_desc.num ? PH_DIGIT : after_tab;
   assign cur_phase    = first_ff ? first_phase : phase_ff;
   assign cur_idx      = first_ff ? '0 : idx_ff;

   // Pick the digit at the current column; blank leading zeros except the last.
   always_comb begin
      seen     = 1'b0;
      is_blank = 1'b0;
      sel_dgt  = 4'd0;
      for (int k = 0; k < NUMBER_DIGITS; k++) begin
         dgt  = q_num[4*(NUMBER_DIGITS-1-k) +: 4];
         seen = seen || (dgt != 4'd0);
         if (cur_idx == IW'(k)) begin
            sel_dgt  = dgt;
            is_blank = !seen && (k != NUMBER_DIGITS - 1);
         end
      end
      digit_char = is_blank ? CH_SPACE : {4'h3, sel_dgt};
   end

   always_comb begin
      step_byte  = q_desc.ch;
      next_phase = PH_CHAR;
      next_idx   = cur_idx;
      case (cur_phase)
         PH_DIGIT: begin
            step_byte = digit_char;
            if (cur_idx == LAST_IDX) begin
               next_phase = PH_TAB;
            end else begin
               next_phase = PH_DIGIT;
               next_idx   = cur_idx + IW'(1);
            end
         end
         PH_TAB: begin
            step_byte  = CH_TAB;
            next_phase = after_tab;
         end
         PH_DOLLAR: begin
            step_byte  = CH_DOLLAR;
            next_phase = after_dollar;
         end
         PH_M: begin
            step_byte  = CH_UPPER_M;
            next_phase = PH_DASH;
         end
         PH_DASH: begin
            step_byte  = CH_DASH;
            next_phase = (q_desc.prefix == PFX_MDASH_CARET) ? PH_CARET : PH_CHAR;
         end
         PH_CARET: begin
            step_byte  = CH_CARET;
            next_phase = PH_CHAR;
         end
         PH_CHAR: begin
            step_byte  = q_desc.ch;
            next_phase = PH_CHAR;
         end
         default: begin
            step_byte  = q_desc.ch;
            next_phase = PH_CHAR;
         end
      endcase
   end

   assign advance = !q_empty && (!valid_ff || rsp_pop);
   assign q_pop   = advance && (cur_phase == PH_CHAR);

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         phase_ff <= PH_CHAR;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            valid_ff <= 1'b1;
            if (cur_phase == PH_CHAR) begin
               first_ff <= 1'b1;
            end else begin
               first_ff <= 1'b0;
               phase_ff <= next_phase;
               idx_ff   <= next_idx;
            end
         end else if (rsp_pop) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= step_byte;
         last_ff <= (cur_phase == PH_CHAR);
      end
   end

   assign rsp_empty    = !valid_ff;
   assign rsp_out_byte = byte_ff;
   assign rsp_last     = last_ff;

endmodule

### hw/rtl/text_stream_show_and_number.sv
// ----------------------------------------------------------------------------
// text_stream_show_and_number: byte stream display filter
// Classifier, descriptor queue and byte sequencer of the display filter.
// ----------------------------------------------------------------------------
// The block takes one input beat per cycle (data byte or end-of-file mark)
// while the descriptor queue has room, and gives one display byte per cycle
// while rsp_pop reads. A data byte expands to 1 to NUMBER_DIGITS + 5 bytes
// (11 at the default: six digits, tab, M, dash, caret, character), set by the
// byte sequencer; end-of-file marks and squeezed newlines give no bytes. The
// input side accepts while results wait, until QUEUE_DEPTH descriptors are
// queued, the one being expanded among them. Line numbers saturate at all
// nines. Options are to be written through the csr port while the block is
// idle, which the block does not enforce; the csr port is always ready.
module text_stream_show_and_number #(
   parameter int NUMBER_DIGITS = 6,
   parameter int QUEUE_DEPTH   = 2
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tsn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic                             csr_data,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_cmd,
   input  logic [7:0]                       req_in_byte,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [7:0]                       rsp_out_byte,
   output logic                             rsp_last
);
   import tsn_pkg::*;

   localparam int NW = 4 * NUMBER_DIGITS;
   localparam int QW = $bits(desc_type) + NW;

   logic            q_push, q_full, q_pop, q_empty;
   desc_type        push_desc, head_desc;
   logic [NW-1:0]   push_num, head_num;
   logic [QW-1:0]   head_word;

   tsn_front #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_cmd     (req_cmd),
      .req_in_byte (req_in_byte),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_desc      (push_desc),
      .q_num       (push_num)
   );

   tsn_fifo #(.WIDTH(QW), .DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({push_desc, push_num}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (head_word),
      .empty     (q_empty)
   );

   assign head_desc = desc_type'(head_word[QW-1:NW]);
   assign head_num  = head_word[NW-1:0];

   tsn_back #(.NUMBER_DIGITS(NUMBER_DIGITS)) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_empty      (q_empty),
      .q_desc       (head_desc),
      .q_num        (head_num),
      .q_pop        (q_pop),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule

### hw/rtl/tsn_checker.sv
// ----------------------------------------------------------------------------
// tsn_checker: port checks of the display filter
// Watches the top level's ports and flags handshake and flow errors.
// ----------------------------------------------------------------------------
module tsn_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             csr_valid,
   input logic                             csr_ready,
   input logic [tsn_pkg::CSR_INDEX_W-1:0]  csr_index,
   input logic                             req_full,
   input logic                             rsp_empty,
   input logic                             rsp_pop,
   input logic [7:0]                       rsp_out_byte,
   input logic                             rsp_last
);
   import tsn_pkg::*;

   // nothing can be waiting right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or full flag shown right after reset");

   // a full queue always has a byte at the output
   a_full_has_output: assert property (@(posedge clock) disable iff (reset)
      req_full |-> !rsp_empty)
      else $error("input stalled with no result on offer");

   // a stalled result beat holds
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_out_byte) && $stable(rsp_last))
      else $error("result beat changed while stalled");

   // a csr beat is taken at once and carries a known index
   a_csr_taken: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready && !$isunknown(csr_index))
      else $error("csr beat not taken or index unknown");

endmodule

bind text_stream_show_and_number tsn_checker u_tsn_checker (
   .clock        (clock),
   .reset        (reset),
   .csr_valid    (csr_valid),
   .csr_ready    (csr_ready),
   .csr_index    (csr_index),
   .req_full     (req_full),
   .rsp_empty    (rsp_empty),
   .rsp_pop      (rsp_pop),
   .rsp_out_byte (rsp_out_byte),
   .rsp_last     (rsp_last)
);
